// File: design/g2e_pkg.sv
// ----------------------------------------------------------------------------
// g2e_pkg: shared types and constants for the geodetic to ECEF X converter
// Field widths, fixed-point formats, register indexes and the CORDIC
// stage-angle table used by the converter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package g2e_pkg;

  localparam int ANG_W = 32;
  localparam int H_W   = 32;
  localparam int A_W   = 33;
  localparam int E2_W  = 32;
  localparam int N_W   = 33;
  localparam int X_W   = 35;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 33;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECC    = 2'd1;

  localparam logic [A_W-1:0]  RADIUS_RST = 33'd6378137000;
  localparam logic [E2_W-1:0] ECC_RST    = 32'd28752143;

  // cordic datapath: x, y in Q40, z in Q61
  localparam int XY_W = 44;
  localparam int Z_W  = 64;

  localparam logic [62:0] PI_Q61 = 63'h6487ED5110B4611A;
  localparam logic signed [XY_W-1:0] K_Q40 = 44'sd667681663043;

  localparam logic [N_W-1:0]        N_MAX = 33'h1FFFFFFFF;
  localparam logic signed [X_W-1:0] X_MAX = 35'sh3FFFFFFFF;
  localparam logic signed [X_W-1:0] X_MIN = 35'sh400000000;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  function automatic logic [63:0] atan_pw(input int i, input int d);
    if (i * d <= 61) begin
      return 64'd1 << (61 - i * d);
    end
    return 64'd0;
  endfunction

  // atan(2^-i) in Q61 as a truncated arctangent series
  function automatic logic [63:0] atan_q61(input int i);
    logic [63:0] s;
    if (i == 0) begin
      return 64'(PI_Q61) >> 2;
    end
    s = atan_pw(i, 1) - atan_pw(i, 3) / 3 + atan_pw(i, 5) / 5 - atan_pw(i, 7) / 7
      + atan_pw(i, 9) / 9 - atan_pw(i, 11) / 11 + atan_pw(i, 13) / 13
      - atan_pw(i, 15) / 15 + atan_pw(i, 17) / 17 - atan_pw(i, 19) / 19
      + atan_pw(i, 21) / 21 - atan_pw(i, 23) / 23 + atan_pw(i, 25) / 25
      - atan_pw(i, 27) / 27 + atan_pw(i, 29) / 29 - atan_pw(i, 31) / 31
      + atan_pw(i, 33) / 33 - atan_pw(i, 35) / 35 + atan_pw(i, 37) / 37
      - atan_pw(i, 39) / 39 + atan_pw(i, 41) / 41 - atan_pw(i, 43) / 43
      + atan_pw(i, 45) / 45 - atan_pw(i, 47) / 47 + atan_pw(i, 49) / 49
      - atan_pw(i, 51) / 51 + atan_pw(i, 53) / 53 - atan_pw(i, 55) / 55
      + atan_pw(i, 57) / 57 - atan_pw(i, 59) / 59 + atan_pw(i, 61) / 61;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/g2e_if.sv
// ----------------------------------------------------------------------------
// g2e_if: valid/ready channels of the geodetic to ECEF X converter
// Position input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface g2e_in_if;
  import g2e_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] lat_angle;
  logic signed [ANG_W-1:0] lon_angle;
  logic signed [H_W-1:0]   height_mm;

  modport source (output valid, lat_angle, lon_angle, height_mm, input ready);
  modport sink   (input valid, lat_angle, lon_angle, height_mm, output ready);
endinterface

interface g2e_out_if;
  import g2e_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [N_W-1:0]        prime_vertical_mm;
  logic signed [X_W-1:0] ecef_x_mm;

  modport source (output valid, prime_vertical_mm, ecef_x_mm, input ready);
  modport sink   (input valid, prime_vertical_mm, ecef_x_mm, output ready);
endinterface

interface g2e_cfg_if;
  import g2e_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/g2e_cell.sv
// ----------------------------------------------------------------------------
// g2e_cell: one CORDIC rotation stage
// Rotates the latitude and longitude vectors by +-atan(2^-I) and hands the
// result and the side data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_cell #(
  parameter int I  = 0,
  parameter int SW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SW-1:0]          side_i,
  input  g2e_pkg::rot_t [1:0]    rot_i,
  output logic                   valid_o,
  output logic [SW-1:0]          side_o,
  output g2e_pkg::rot_t [1:0]    rot_o
);
  import g2e_pkg::*;

  localparam logic signed [Z_W-1:0] DA = Z_W'(atan_q61(I));

  rot_t [1:0] rot_d, rot_q;
  logic       valid_q;
  logic [SW-1:0] side_q;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [XY_W-1:0] dx, dy;
    assign dx = $signed(rot_i[l].y) >>> I;
    assign dy = $signed(rot_i[l].x) >>> I;
    always_comb begin
      if (!rot_i[l].z[Z_W-1]) begin
        rot_d[l].x = rot_i[l].x - dx;
        rot_d[l].y = rot_i[l].y + dy;
        rot_d[l].z = rot_i[l].z - DA;
      end else begin
        rot_d[l].x = rot_i[l].x + dx;
        rot_d[l].y = rot_i[l].y - dy;
        rot_d[l].z = rot_i[l].z + DA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rot_o   = rot_q;

endmodule

`default_nettype wire

// File: design/g2e_mul.sv
// ----------------------------------------------------------------------------
// g2e_mul: two-stage unsigned multiplier
// Four partial products, split at bit 32, in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_mul #(
  parameter int WA = 33,
  parameter int WB = 33,
  parameter int SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [SW-1:0]      side_i,
  input  logic [WA-1:0]      a_i,
  input  logic [WB-1:0]      b_i,
  output logic               valid_o,
  output logic [SW-1:0]      side_o,
  output logic [WA+WB-1:0]   p_o
);

  localparam int PW = WA + WB;
  localparam int AH = WA - 32;
  localparam int BH = WB - 32;

  logic [63:0]      p00_q;
  logic [WB-1:0]    p01_q;
  logic [WA-1:0]    p10_q;
  logic [AH+BH-1:0] p11_q;
  logic [PW-1:0]    p_q;
  logic             v1_q, v2_q;
  logic [SW-1:0]    s1_q, s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= a_i[31:0] * b_i[31:0];
      p01_q <= a_i[31:0] * b_i[WB-1:32];
      p10_q <= a_i[WA-1:32] * b_i[31:0];
      p11_q <= a_i[WA-1:32] * b_i[WB-1:32];
      s1_q  <= side_i;
      p_q   <= PW'(p00_q) + (PW'(p01_q) << 32) + (PW'(p10_q) << 32) + (PW'(p11_q) << 64);
      s2_q  <= s1_q;
    end
  end

  assign valid_o = v2_q;
  assign side_o  = s2_q;
  assign p_o     = p_q;

endmodule

`default_nettype wire

// File: design/g2e_sqrt.sv
// ----------------------------------------------------------------------------
// g2e_sqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] side_i,
  input  logic [63:0]   v_i,
  output logic          valid_o,
  output logic [SW-1:0] side_o,
  output logic [31:0]   r_o
);

  logic [33:0]   rem_q  [32];
  logic [31:0]   root_q [32];
  logic [63:0]   v_q    [32];
  logic          vld_q  [32];
  logic [SW-1:0] side_q [32];

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [33:0]   rem_p;
    logic [31:0]   root_p;
    logic [63:0]   v_p;
    logic          vld_p;
    logic [SW-1:0] side_p;
    logic [35:0]   rem_sh, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign v_p    = v_i;
      assign vld_p  = valid_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign v_p    = v_q[k-1];
      assign vld_p  = vld_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign rem_sh = {rem_p, v_p[63:62]};
    assign trial  = {2'b00, root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_q[k] <= {root_p[30:0], ge};
        v_q[k]    <= v_p << 2;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[31];
  assign side_o  = side_q[31];
  assign r_o     = root_q[31];

endmodule

`default_nettype wire

// File: design/g2e_div.sv
// ----------------------------------------------------------------------------
// g2e_div: pipelined restoring divider
// 33-bit quotient of a 64-bit dividend by a 32-bit divisor, one bit per
// stage; the caller flags quotients that do not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_div #(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [SW-1:0] side_i,
  input  logic [63:0]   num_i,
  input  logic [31:0]   den_i,
  output logic          valid_o,
  output logic [SW-1:0] side_o,
  output logic [32:0]   q_o
);

  localparam int NS = 33;

  logic [31:0]   rem_q  [NS];
  logic [32:0]   q_q    [NS];
  logic [32:0]   nb_q   [NS];
  logic [31:0]   den_q  [NS];
  logic          vld_q  [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [31:0]   rem_p, den_p;
    logic [32:0]   q_p, nb_p, rem_sh;
    logic          vld_p, ge;
    logic [SW-1:0] side_p;

    if (k == 0) begin : g_first
      assign rem_p  = {1'b0, num_i[63:33]};
      assign q_p    = '0;
      assign nb_p   = num_i[32:0];
      assign den_p  = den_i;
      assign vld_p  = valid_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign q_p    = q_q[k-1];
      assign nb_p   = nb_q[k-1];
      assign den_p  = den_q[k-1];
      assign vld_p  = vld_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign rem_sh = {rem_p, nb_p[32]};
    assign ge     = rem_sh >= {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 32'(rem_sh - {1'b0, den_p}) : rem_sh[31:0];
        q_q[k]    <= {q_p[31:0], ge};
        nb_q[k]   <= nb_p << 1;
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign q_o     = q_q[NS-1];

endmodule

`default_nettype wire

// File: design/geodetic_to_ecef_x.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef_x: geodetic position to prime-vertical radius and ECEF X
// Throughput: one position per cycle; every unit is fully pipelined, the
// CORDIC row has one cell per rotation, the root and divider one per bit.
// The whole pipe holds only while a result waits at the output.
// Reset clears all valid bits and loads the WGS-84 radius and eccentricity.
// ----------------------------------------------------------------------------
`default_nettype none

module geodetic_to_ecef_x #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  g2e_in_if.sink      in_i,
  g2e_out_if.source   out_o,
  g2e_cfg_if.sink     cfg_i
);
  import g2e_pkg::*;

  typedef struct packed {
    logic        flip;
    logic        neg;
    logic [30:0] mag;
  } ang_t;

  typedef struct packed {
    logic           flip_lat;
    logic           flip_lon;
    logic [H_W-1:0] h;
  } chain_side_t;

  typedef struct packed {
    logic           xs;
    logic [H_W-1:0] h;
    logic [41:0]    c;
  } mid_t;

  typedef struct packed {
    logic sat;
    mid_t mid;
  } div_side_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic           xneg;
  } fin_t;

  function automatic ang_t reduce(input logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W:0] a;
    logic [ANG_W:0]        m;
    ang_t                  r;
    a = {ang[ANG_W-1], ang};
    r.flip = (a > 33'sd1073741824) || (a < -33'sd1073741824);
    if (r.flip) begin
      a = a[ANG_W] ? a + 33'sd2147483648 : a - 33'sd2147483648;
    end
    r.neg = a[ANG_W];
    m     = a[ANG_W] ? 33'(-a) : 33'(a);
    r.mag = m[30:0];
    return r;
  endfunction

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // configuration
  logic [A_W-1:0]  radius_q;
  logic [E2_W-1:0] ecc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      ecc_q    <= ECC_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RADIUS: radius_q <= cfg_i.data[A_W-1:0];
        REG_ECC:    ecc_q    <= cfg_i.data[E2_W-1:0];
        default: ;
      endcase
    end
  end

  // angle reduction
  ang_t           lat_a_q, lon_a_q;
  logic [H_W-1:0] h_a_q;
  logic           va_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_a_q <= reduce(in_i.lat_angle);
      lon_a_q <= reduce(in_i.lon_angle);
      h_a_q   <= in_i.height_mm;
    end
  end

  // conversion to radians
  logic [95:0]    p_rlat, p_rlon;
  logic           v_rad;
  logic [H_W+1:0] s_rlat;
  logic [1:0]     s_rlon;

  g2e_mul #(.WA(33), .WB(63), .SW(H_W + 2)) u_mul_rlat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va_q),
    .side_i({lat_a_q.neg, lat_a_q.flip, h_a_q}),
    .a_i(33'(lat_a_q.mag)), .b_i(PI_Q61),
    .valid_o(v_rad), .side_o(s_rlat), .p_o(p_rlat)
  );

  g2e_mul #(.WA(33), .WB(63), .SW(2)) u_mul_rlon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va_q),
    .side_i({lon_a_q.neg, lon_a_q.flip}),
    .a_i(33'(lon_a_q.mag)), .b_i(PI_Q61),
    .valid_o(), .side_o(s_rlon), .p_o(p_rlon)
  );

  logic [95:0]           rs_lat, rs_lon;
  logic signed [Z_W-1:0] z_lat, z_lon;
  assign rs_lat = p_rlat + (96'd1 << 30);
  assign rs_lon = p_rlon + (96'd1 << 30);
  assign z_lat  = s_rlat[H_W+1] ? -$signed(rs_lat[94:31]) : $signed(rs_lat[94:31]);
  assign z_lon  = s_rlon[1] ? -$signed(rs_lon[94:31]) : $signed(rs_lon[94:31]);

  // cordic row
  rot_t [1:0]  rot_c  [CORDIC_STAGES+1];
  logic        vld_c  [CORDIC_STAGES+1];
  chain_side_t side_c [CORDIC_STAGES+1];

  assign rot_c[0][0] = '{x: K_Q40, y: '0, z: z_lat};
  assign rot_c[0][1] = '{x: K_Q40, y: '0, z: z_lon};
  assign vld_c[0]    = v_rad;
  assign side_c[0]   = '{flip_lat: s_rlat[H_W], flip_lon: s_rlon[0], h: s_rlat[H_W-1:0]};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    g2e_cell #(.I(i), .SW($bits(chain_side_t))) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vld_c[i]), .side_i(side_c[i]), .rot_i(rot_c[i]),
      .valid_o(vld_c[i+1]), .side_o(side_c[i+1]), .rot_o(rot_c[i+1])
    );
  end

  // signs and magnitudes
  rot_t [1:0]             rot_e;
  chain_side_t            side_e;
  logic signed [XY_W-1:0] cl, sl, co;
  logic [42:0]            msl_q, mcl_q, mco_q;
  logic                   xs_q, vf_q;
  logic [H_W-1:0]         h_f_q;

  assign rot_e  = rot_c[CORDIC_STAGES];
  assign side_e = side_c[CORDIC_STAGES];
  assign cl = side_e.flip_lat ? -rot_e[0].x : rot_e[0].x;
  assign sl = side_e.flip_lat ? -rot_e[0].y : rot_e[0].y;
  assign co = side_e.flip_lon ? -rot_e[1].x : rot_e[1].x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= vld_c[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msl_q <= sl[XY_W-1] ? 43'(-sl) : 43'(sl);
      mcl_q <= cl[XY_W-1] ? 43'(-cl) : 43'(cl);
      mco_q <= co[XY_W-1] ? 43'(-co) : 43'(co);
      xs_q  <= cl[XY_W-1] ^ co[XY_W-1];
      h_f_q <= side_e.h;
    end
  end

  // sin^2 and cos*cos
  logic [85:0]    p_s2, p_c;
  logic           v_s2, xs_m;
  logic [H_W-1:0] h_m;

  g2e_mul #(.WA(43), .WB(43), .SW(H_W)) u_mul_s2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vf_q), .side_i(h_f_q),
    .a_i(msl_q), .b_i(msl_q),
    .valid_o(v_s2), .side_o(h_m), .p_o(p_s2)
  );

  g2e_mul #(.WA(43), .WB(43), .SW(1)) u_mul_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vf_q), .side_i(xs_q),
    .a_i(mcl_q), .b_i(mco_q),
    .valid_o(), .side_o(xs_m), .p_o(p_c)
  );

  logic [85:0] rs_s2, rs_c;
  mid_t        mid_s2;
  assign rs_s2  = p_s2 + (86'd1 << 39);
  assign rs_c   = p_c + (86'd1 << 39);
  assign mid_s2 = '{xs: xs_m, h: h_m, c: rs_c[81:40]};

  // e2 * sin^2
  logic [74:0] p_t, rs_t;
  logic [42:0] t;
  logic        v_t;
  mid_t        mid_t_s;

  g2e_mul #(.WA(33), .WB(42), .SW($bits(mid_t))) u_mul_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_s2), .side_i(mid_s2),
    .a_i(33'(ecc_q)), .b_i(rs_s2[81:40]),
    .valid_o(v_t), .side_o(mid_t_s), .p_o(p_t)
  );

  assign rs_t = p_t + (75'd1 << 31);
  assign t    = rs_t[74:32];

  logic [40:0] d_q;
  mid_t        mid_d_q;
  logic        vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= v_t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q     <= (t >= (43'd1 << 40)) ? '0 : 41'((43'd1 << 40) - t);
      mid_d_q <= mid_t_s;
    end
  end

  // root of 1 - e2 sin^2
  logic [31:0] r;
  logic        v_r;
  mid_t        mid_r;

  g2e_sqrt #(.SW($bits(mid_t))) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vd_q), .side_i(mid_d_q),
    .v_i(64'(d_q) << 22),
    .valid_o(v_r), .side_o(mid_r), .r_o(r)
  );

  logic [63:0] num;
  logic [63:0] num_q;
  logic [31:0] den_q;
  div_side_t   dsd_q;
  logic        vq_q;

  assign num = {radius_q, 31'd0} + 64'(r >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else if (en) begin
      vq_q <= v_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num;
      den_q <= r;
      dsd_q <= '{sat: (r == '0) || ({1'b0, num[63:33]} >= r), mid: mid_r};
    end
  end

  // radius over root
  logic [32:0] q;
  logic        v_q;
  div_side_t   dsd_o;

  g2e_div #(.SW($bits(div_side_t))) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq_q), .side_i(dsd_q),
    .num_i(num_q), .den_i(den_q),
    .valid_o(v_q), .side_o(dsd_o), .q_o(q)
  );

  logic [N_W-1:0]        n;
  logic signed [X_W-1:0] m;
  logic [N_W-1:0]        n_m_q;
  logic [33:0]           mm_q;
  logic [41:0]           c_m_q;
  logic                  xneg_m_q, vm_q;

  assign n = dsd_o.sat ? N_MAX : q;
  assign m = $signed({2'b00, n}) + $signed({{3{dsd_o.mid.h[H_W-1]}}, dsd_o.mid.h});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_m_q    <= n;
      mm_q     <= m[X_W-1] ? 34'(-m) : 34'(m);
      c_m_q    <= dsd_o.mid.c;
      xneg_m_q <= dsd_o.mid.xs ^ m[X_W-1];
    end
  end

  // (N + h) * cos * cos
  logic [75:0] p_x, rs_x;
  logic [35:0] pr;
  logic        v_x;
  fin_t        fin;

  g2e_mul #(.WA(34), .WB(42), .SW($bits(fin_t))) u_mul_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vm_q),
    .side_i(fin_t'{n: n_m_q, xneg: xneg_m_q}),
    .a_i(mm_q), .b_i(c_m_q),
    .valid_o(v_x), .side_o(fin), .p_o(p_x)
  );

  assign rs_x = p_x + (76'd1 << 39);
  assign pr   = rs_x[75:40];

  logic signed [X_W-1:0] x_d, x_q;
  logic [N_W-1:0]        n_q;
  logic                  out_valid_q;

  always_comb begin
    if (!fin.xneg) begin
      x_d = (pr > 36'(X_MAX)) ? X_MAX : $signed(pr[X_W-1:0]);
    end else begin
      x_d = (pr > (36'd1 << 34)) ? X_MIN : -$signed(pr[X_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= x_d;
      n_q <= fin.n;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.prime_vertical_mm = n_q;
  assign out_o.ecef_x_mm         = x_q;

endmodule

`default_nettype wire

// File: design/g2e_checker.sv
// ----------------------------------------------------------------------------
// g2e_checker: port-level checks for the geodetic to ECEF X converter
// Tracks transfers in flight and checks output hold and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module g2e_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [32:0] out_n_i,
  input logic [34:0] out_x_i
);

  logic [7:0] count_q, count_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (in_xfer && !out_xfer) begin
      count_d = count_q + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      count_d = count_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_n_i) && $stable(out_x_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_q != 8'd0)
    else $error("result without a pending input");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

bind geodetic_to_ecef_x g2e_checker u_g2e_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_n_i    (out_o.prime_vertical_mm),
  .out_x_i    (out_o.ecef_x_mm)
);

`default_nettype wire

// File: verif/tb_geodetic_to_ecef_x.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_geodetic_to_ecef_x: self-checking testbench for the ECEF X converter
// A queued driver feeds positions with random gaps (none in one phase). A monitor checks each
// result against a fixed-point predictor in order. Radius and eccentricity
// are rewritten between idle phases. One phase holds the output back long
// enough to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_geodetic_to_ecef_x;
  import g2e_pkg::*;

  localparam int STAGES    = 32;
  localparam int LATENCY   = STAGES + 79;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 400;
  localparam int IDLE_PCT  = 28;

  typedef struct packed {
    logic signed [ANG_W-1:0] lat;
    logic signed [ANG_W-1:0] lon;
    logic signed [H_W-1:0]   h;
  } position_t;

  typedef struct packed {
    logic [N_W-1:0]        n;
    logic signed [X_W-1:0] x;
  } ecef_t;

  logic clk_i;
  logic rst_ni;

  g2e_in_if  in_bus ();
  g2e_out_if out_bus ();
  g2e_cfg_if cfg_bus ();

  geodetic_to_ecef_x #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  position_t   positions_q[$];
  ecef_t       ecef_due_q[$];
  logic [A_W-1:0]  radius_mm;
  logic [E2_W-1:0] ecc_q32;
  int unsigned cycles;
  int unsigned mismatches;
  bit          no_gaps;
  bit          hold_req;
  bit          hold_done;
  int          hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                int sh, bit rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (rnd) begin
      p = p + (128'd1 << (sh - 1));
    end
    p = p >> sh;
    if (p[127:64] != 0) begin
      return 64'hFFFF_FFFF_FFFF_FFFF;
    end
    return p[63:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint stage_angle(int i);
    longint sum;
    int     e;
    sum = 0;
    if (i == 0) begin
      return longint'(64'(PI_Q61) >> 2);
    end
    for (int k = 0; ; k++) begin
      e = i * (2 * k + 1);
      if (e > 61) break;
      if (k % 2 == 1) begin
        sum = sum - longint'((64'd1 << (61 - e)) / (2 * k + 1));
      end else begin
        sum = sum + longint'((64'd1 << (61 - e)) / (2 * k + 1));
      end
    end
    return sum;
  endfunction

  function automatic void rotate(longint angle, output longint cs, output longint sn);
    bit     flip;
    bit     neg;
    longint x, y, z, rad, dx, dy;
    flip = 0;
    x = longint'(K_Q40);
    y = 0;
    if (angle > (64'sd1 <<< 30) || angle < -(64'sd1 <<< 30)) begin
      flip = 1;
      angle = angle >= 0 ? angle - (64'sd1 <<< 31) : angle + (64'sd1 <<< 31);
    end
    neg = angle < 0;
    rad = longint'(mul_shift(magnitude(angle), 64'(PI_Q61), 31, 1));
    z = neg ? -rad : rad;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - stage_angle(i);
      end else begin
        x = x + dx; y = y - dy; z = z + stage_angle(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic ecef_t convert(position_t pos);
    longint          cl, sl, co, so, m, x;
    longint unsigned s2, t, d, r, n, c, p;
    bit              xneg;
    ecef_t           res;
    rotate(longint'(pos.lat), cl, sl);
    rotate(longint'(pos.lon), co, so);
    s2 = mul_shift(magnitude(sl), magnitude(sl), 40, 1);
    t = mul_shift(64'(ecc_q32), s2, 32, 1);
    d = t >= (64'd1 << 40) ? 64'd0 : (64'd1 << 40) - t;
    r = int_sqrt(d << 22);
    if (r == 0) begin
      n = 64'(N_MAX);
    end else begin
      n = ((64'(radius_mm) << 31) + (r >> 1)) / r;
      if (n > 64'(N_MAX)) n = 64'(N_MAX);
    end
    m = longint'(n) + longint'(pos.h);
    c = mul_shift(magnitude(cl), magnitude(co), 40, 1);
    xneg = ((cl < 0) != (co < 0)) != (m < 0);
    p = mul_shift(magnitude(m), c, 40, 1);
    if (!xneg) begin
      x = p > 64'(X_MAX) ? longint'(X_MAX) : longint'(p);
    end else begin
      x = p > (64'd1 << 34) ? longint'(X_MIN) : -longint'(p);
    end
    res.n = n[N_W-1:0];
    res.x = x[X_W-1:0];
    return res;
  endfunction

  function automatic position_t random_position();
    position_t pos;
    pos.lat = 32'($signed(33'($urandom_range(32'h8000_0000, 0))) - 33'sd1073741824);
    pos.lon = $urandom;
    case ($urandom_range(3, 0))
      0:       pos.h = $urandom;
      1:       pos.h = 32'($signed($urandom_range(20000000, 0)) - 10000000);
      default: pos.h = 32'($signed($urandom_range(100000, 0)) - 500);
    endcase
    return pos;
  endfunction

  function automatic void add_position(logic [31:0] lat, logic [31:0] lon, logic [31:0] h);
    position_t pos;
    pos.lat = lat;
    pos.lon = lon;
    pos.h = h;
    positions_q.push_back(pos);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_RADIUS) radius_mm = value[A_W-1:0];
    else if (idx == REG_ECC) ecc_q32 = value[E2_W-1:0];
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (positions_q.size() != 0 || ecef_due_q.size() != 0 || in_bus.valid) begin
      @(negedge clk_i);
    end
  endtask

  task automatic queue_random(int count);
    repeat (count) positions_q.push_back(random_position());
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || in_bus.ready) begin
        if (positions_q.size() != 0 && (no_gaps || $urandom_range(99, 0) >= IDLE_PCT)) begin
          position_t pos;
          pos = positions_q.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.lat_angle <= pos.lat;
          in_bus.lon_angle <= pos.lon;
          in_bus.height_mm <= pos.h;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // predict on every input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      position_t pos;
      pos.lat = in_bus.lat_angle;
      pos.lon = in_bus.lon_angle;
      pos.h = in_bus.height_mm;
      ecef_due_q.push_back(convert(pos));
    end
  end

  // output back-pressure with one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_gaps || $urandom_range(99, 0) >= IDLE_PCT;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (ecef_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        ecef_t due;
        due = ecef_due_q.pop_front();
        if (out_bus.prime_vertical_mm !== due.n || out_bus.ecef_x_mm !== due.x) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: n exp %0d act %0d, x exp %0d act %0d",
                     due.n, out_bus.prime_vertical_mm, due.x, out_bus.ecef_x_mm);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    no_gaps = 0;
    hold_req = 0;
    hold_done = 0;
    hold_left = 0;
    radius_mm = RADIUS_RST;
    ecc_q32 = ECC_RST;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.lat_angle = '0;
    in_bus.lon_angle = '0;
    in_bus.height_mm = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset ellipsoid, field extremes and quadrant edges
    add_position(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_position(32'h4000_0000, 32'h0000_0000, 32'h0000_0000);
    add_position(32'hC000_0000, 32'h0000_0000, 32'h0000_0000);
    add_position(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
    add_position(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_position(32'h0000_0000, 32'h4000_0000, 32'h8000_0000);
    add_position(32'h0000_0000, 32'h4000_0001, 32'h0000_03E8);
    add_position(32'h0000_0000, 32'hBFFF_FFFF, 32'hFFFF_FC18);
    add_position(32'h2000_0000, 32'h2000_0000, 32'h7FFF_FFFF);
    add_position(32'hE000_0000, 32'hA000_0000, 32'h8000_0000);
    add_position(32'h3FFF_FFFF, 32'h6000_0000, 32'h0001_0000);
    add_position(32'hC000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    add_position(32'h1555_5555, 32'hD555_5555, 32'h8000_0000);
    add_position(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_random(300);
    wait_drained();

    // largest radius with unit eccentricity: root collapses at the poles
    write_reg(REG_RADIUS, 33'h1_FFFF_FFFF);
    write_reg(REG_ECC, 33'h0_FFFF_FFFF);
    add_position(32'h4000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    add_position(32'hC000_0000, 32'h8000_0000, 32'h8000_0000);
    add_position(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    add_position(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_position(32'h3000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_random(150);
    wait_drained();

    // smallest radius, sphere
    write_reg(REG_RADIUS, 33'd1);
    write_reg(REG_ECC, 33'd0);
    queue_random(150);
    wait_drained();

    // back to WGS-84 with the output held off
    write_reg(REG_RADIUS, 33'(RADIUS_RST));
    write_reg(REG_ECC, 33'(ECC_RST));
    hold_req = 1'b1;
    queue_random(300);
    wait_drained();

    // half eccentricity, no gaps on either side
    write_reg(REG_ECC, 33'h0_8000_0000);
    no_gaps = 1'b1;
    queue_random(150);
    wait_drained();
    no_gaps = 1'b0;

    // random ellipsoid
    write_reg(REG_RADIUS, {$urandom_range(1, 0), 32'($urandom)} | 33'd1);
    write_reg(REG_ECC, 33'($urandom));
    queue_random(250);
    wait_drained();

    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && ecef_due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
